### design/batch_norm_inference_defines.svh
// assertion macros shared by the batch norm rtl
// no dependencies; expects clk_i and rst_ni in the including module
`ifndef BATCH_NORM_INFERENCE_DEFINES_SVH
`define BATCH_NORM_INFERENCE_DEFINES_SVH

// plain check, sampled on the rising clock edge outside reset
`define BNI_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// same-cycle implication
`define BNI_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BNI_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/bni_pkg.sv
// types and constants for the batch norm inference block
// no dependencies
`default_nettype none

package bni_pkg;

  localparam int DATA_WIDTH      = 16;
  localparam int CFG_WIDTH       = 11;
  localparam int CH_WIDTH        = 10;
  localparam int SCALE_WIDTH     = 32;
  localparam int MAX_CHANNELS_DEF = 1024;
  localparam logic [CFG_WIDTH-1:0] NUM_CHANNELS_RST = 11'd64;

  localparam int QUEUE_DEPTH = 4;

  // rsqrt unit: 2^16/sqrt(var/256 + 1e-5), done as isqrt(4*num/den)
  localparam int DIV_STEPS  = 59;
  localparam int DEN_WIDTH  = 33;
  localparam int QUO_WIDTH  = 51;
  localparam int SQRT_STEPS = 26;
  localparam logic [DIV_STEPS-1:0] DIV_NUM = 59'(64'd25600000 << 34);
  localparam logic [16:0] DEN_MUL = 17'd100000;
  localparam logic [8:0]  DEN_ADD = 9'd256;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_LOAD   = 1'b1
  } op_e;

  typedef struct packed {
    op_e                          op;
    logic [CH_WIDTH-1:0]          ch;
    logic signed [DATA_WIDTH-1:0] sample;
    logic                         last;
    logic signed [DATA_WIDTH-1:0] mean;
    logic [DATA_WIDTH-1:0]        variance;
    logic signed [DATA_WIDTH-1:0] gamma;
    logic signed [DATA_WIDTH-1:0] bias;
  } item_t;

  typedef struct packed {
    logic                          done;
    logic signed [SCALE_WIDTH-1:0] scale;
  } rsq_res_t;

endpackage

`default_nettype wire

### design/bni_front.sv
// front end: takes requests, holds num_channels and the channel counter
// depends on bni_pkg
`default_nettype none

module bni_front import bni_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [CFG_WIDTH-1:0]          cfg_wdata_i,
  input  wire logic                          in_valid_i,
  input  wire logic                          operation_i,
  input  wire logic [CH_WIDTH-1:0]           channel_index_i,
  input  wire logic signed [DATA_WIDTH-1:0]  sample_value_i,
  input  wire logic                          last_in_image_i,
  input  wire logic signed [DATA_WIDTH-1:0]  channel_mean_i,
  input  wire logic [DATA_WIDTH-1:0]         channel_variance_i,
  input  wire logic signed [DATA_WIDTH-1:0]  channel_gamma_i,
  input  wire logic signed [DATA_WIDTH-1:0]  channel_bias_i,
  input  wire logic                          full_i,
  output logic                               push_o,
  output item_t                              item_o
);

  logic [CFG_WIDTH-1:0] num_ch_q;
  logic [CH_WIDTH-1:0]  cnt_q, cnt_d;
  logic [CH_WIDTH:0]    cnt_inc;
  op_e                  op;

  assign op      = op_e'(operation_i);
  assign push_o  = in_valid_i && !full_i;
  assign cnt_inc = {1'b0, cnt_q} + (CH_WIDTH+1)'(1);

  always_comb begin
    cnt_d = cnt_q;
    if (push_o && op == OP_SAMPLE) begin
      if (last_in_image_i || cnt_inc >= num_ch_q) begin
        cnt_d = '0;
      end else begin
        cnt_d = cnt_inc[CH_WIDTH-1:0];
      end
    end
  end

  always_comb begin
    item_o.op       = op;
    item_o.ch       = (op == OP_LOAD) ? channel_index_i : cnt_q;
    item_o.sample   = sample_value_i;
    item_o.last     = last_in_image_i;
    item_o.mean     = channel_mean_i;
    item_o.variance = channel_variance_i;
    item_o.gamma    = channel_gamma_i;
    item_o.bias     = channel_bias_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_ch_q <= NUM_CHANNELS_RST;
      cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        num_ch_q <= cfg_wdata_i;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### design/bni_queue.sv
// short request queue between front and back end
// depends on bni_pkg and the assertion macro header
`default_nettype none
`include "batch_norm_inference_defines.svh"

module bni_queue import bni_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  item_t      item_i,
  output logic       full_o,
  output logic       valid_o,
  output item_t      head_o,
  input  wire logic  pop_i
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  item_t            mem_q [QUEUE_DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [PW:0]      cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PW'(1);
      if (pop_i)  rd_q <= rd_q + PW'(1);
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

  `BNI_ASSERT(a_q_count, cnt_q <= (PW+1)'(QUEUE_DEPTH), "queue count past depth")
  `BNI_ASSERT_IMP(a_q_nopushfull, full_o, !push_i, "push into full queue")
  `BNI_ASSERT_IMP(a_q_nopopempty, !valid_o, !pop_i, "pop from empty queue")

endmodule

`default_nettype wire

### design/bni_rsqrt.sv
// load unit: scale = sat32(floor(gamma * round(2^16/sqrt(var/256+1e-5)) / 2^8))
// bit-serial divider then digit-serial square root; depends on bni_pkg
`default_nettype none
`include "batch_norm_inference_defines.svh"

module bni_rsqrt import bni_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [DATA_WIDTH-1:0]         var_i,
  input  wire logic signed [DATA_WIDTH-1:0]  gamma_i,
  output logic                               busy_o,
  output rsq_res_t                           res_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DEN  = 6'b000010,
    S_DIV  = 6'b000100,
    S_SQRT = 6'b001000,
    S_MUL  = 6'b010000,
    S_SAT  = 6'b100000
  } state_e;

  state_e                         state_q, state_d;
  logic [5:0]                     cnt_q, cnt_d;
  logic [DATA_WIDTH-1:0]          var_q;
  logic signed [DATA_WIDTH-1:0]   gamma_q;
  logic [DEN_WIDTH-1:0]           den_q, den_d;
  logic [DIV_STEPS-1:0]           num_q, num_d;
  logic [DEN_WIDTH-1:0]           rem_q, rem_d;
  logic [QUO_WIDTH-1:0]           quo_q, quo_d;
  logic [2*SQRT_STEPS-1:0]        op_q, op_d;
  logic [SQRT_STEPS-1:0]          root_q, root_d;
  logic [SQRT_STEPS+1:0]          srem_q, srem_d;
  logic signed [42:0]             prod_q, prod_d;
  logic [DEN_WIDTH:0]             rem_sh;
  logic [SQRT_STEPS+3:0]          srem_sh;
  logic [SQRT_STEPS+1:0]          trial;
  logic [SQRT_STEPS-1:0]          rsq;
  logic signed [34:0]             sc_wide;
  logic signed [SCALE_WIDTH-1:0]  sc_sat;

  assign rem_sh  = {rem_q, num_q[DIV_STEPS-1]};
  assign srem_sh = {srem_q, op_q[2*SQRT_STEPS-1 -: 2]};
  assign trial   = {root_q, 2'b01};
  // round half up of sqrt(num/den) from isqrt(4*num/den)
  assign rsq     = SQRT_STEPS'(({1'b0, root_q} + (SQRT_STEPS+1)'(1)) >> 1);
  assign sc_wide = 35'(prod_q >>> 8);

  always_comb begin
    if (sc_wide[34:31] == 4'b0000 || sc_wide[34:31] == 4'b1111) begin
      sc_sat = sc_wide[31:0];
    end else if (sc_wide[34]) begin
      sc_sat = {1'b1, {(SCALE_WIDTH-1){1'b0}}};
    end else begin
      sc_sat = {1'b0, {(SCALE_WIDTH-1){1'b1}}};
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    den_d   = den_q;
    num_d   = num_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    op_d    = op_q;
    root_d  = root_q;
    srem_d  = srem_q;
    prod_d  = prod_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_DEN;
      end
      S_DEN: begin
        den_d   = DEN_WIDTH'(DEN_MUL) * DEN_WIDTH'(var_q) + DEN_WIDTH'(DEN_ADD);
        num_d   = DIV_NUM;
        rem_d   = '0;
        quo_d   = '0;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        num_d = num_q << 1;
        if (rem_sh >= {1'b0, den_q}) begin
          rem_d = DEN_WIDTH'(rem_sh - {1'b0, den_q});
          quo_d = {quo_q[QUO_WIDTH-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[DEN_WIDTH-1:0];
          quo_d = {quo_q[QUO_WIDTH-2:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(DIV_STEPS-1)) begin
          op_d    = (2*SQRT_STEPS)'(quo_d);
          root_d  = '0;
          srem_d  = '0;
          cnt_d   = '0;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        op_d = op_q << 2;
        if (srem_sh >= (SQRT_STEPS+4)'(trial)) begin
          srem_d = (SQRT_STEPS+2)'(srem_sh - (SQRT_STEPS+4)'(trial));
          root_d = {root_q[SQRT_STEPS-2:0], 1'b1};
        end else begin
          srem_d = srem_sh[SQRT_STEPS+1:0];
          root_d = {root_q[SQRT_STEPS-2:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(SQRT_STEPS-1)) state_d = S_MUL;
      end
      S_MUL: begin
        prod_d  = 43'(gamma_q) * 43'($signed({1'b0, rsq}));
        state_d = S_SAT;
      end
      S_SAT: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == S_IDLE) begin
      var_q   <= var_i;
      gamma_q <= gamma_i;
    end
    den_q  <= den_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    op_q   <= op_d;
    root_q <= root_d;
    srem_q <= srem_d;
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_o.done  = (state_q == S_SAT);
  assign res_o.scale = sc_sat;

  `BNI_ASSERT_IMP(a_rs_sqcnt, state_q == S_SQRT, cnt_q < 6'(SQRT_STEPS),
                  "sqrt step count overrun")

endmodule

`default_nettype wire

### design/bni_back.sv
// back end: channel tables, load unit and the three-stage sample pipeline
// depends on bni_pkg, bni_rsqrt and the assertion macro header
`default_nettype none
`include "batch_norm_inference_defines.svh"

module bni_back import bni_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          head_valid_i,
  input  item_t                              head_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [DATA_WIDTH-1:0]       normalized_value_o,
  output logic [CH_WIDTH-1:0]                result_channel_o,
  output logic                               saturated_o,
  output logic                               last_out_o
);

  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic signed [DATA_WIDTH-1:0]  mean_mem  [MAX_CHANNELS];
  logic signed [SCALE_WIDTH-1:0] scale_mem [MAX_CHANNELS];
  logic signed [DATA_WIDTH-1:0]  bias_mem  [MAX_CHANNELS];

  logic                          en, busy, head_inr;
  logic                          pop_sample, pop_load;
  logic [AW-1:0]                 head_addr;
  rsq_res_t                      rsq_res;

  logic [AW-1:0]                 ld_addr_q;
  logic                          ld_inr_q;
  logic signed [DATA_WIDTH-1:0]  ld_mean_q, ld_bias_q;

  logic                          s1_valid_q, s1_last_q, s1_inr_q;
  logic [CH_WIDTH-1:0]           s1_ch_q;
  logic signed [DATA_WIDTH-1:0]  s1_x_q, rd_mean_q, rd_bias_q;
  logic signed [SCALE_WIDTH-1:0] rd_scale_q;

  logic                          s2_valid_q, s2_last_q;
  logic [CH_WIDTH-1:0]           s2_ch_q;
  logic signed [DATA_WIDTH-1:0]  s2_bias_q;
  logic signed [48:0]            s2_prod_q;

  logic                          out_valid_q, out_last_q, out_sat_q;
  logic [CH_WIDTH-1:0]           out_ch_q;
  logic signed [DATA_WIDTH-1:0]  out_y_q;

  logic signed [DATA_WIDTH:0]    diff;
  logic signed [DATA_WIDTH-1:0]  s1_mean, s1_bias;
  logic signed [SCALE_WIDTH-1:0] s1_scale;
  logic signed [33:0]            y_wide;
  logic signed [DATA_WIDTH-1:0]  y_sat;
  logic                          y_ovf;

  assign en         = !(out_valid_q && out_stall_i);
  assign head_addr  = AW'(head_i.ch);
  assign head_inr   = (int'(head_i.ch) < MAX_CHANNELS);
  assign pop_sample = head_valid_i && head_i.op == OP_SAMPLE && en && !busy;
  assign pop_load   = head_valid_i && head_i.op == OP_LOAD && !busy;
  assign pop_o      = pop_sample || pop_load;

  bni_rsqrt u_rsqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (pop_load),
    .var_i   (head_i.variance),
    .gamma_i (head_i.gamma),
    .busy_o  (busy),
    .res_o   (rsq_res)
  );

  // tables: one write port from the load unit, one registered read port
  always_ff @(posedge clk_i) begin
    if (rsq_res.done && ld_inr_q) begin
      mean_mem[ld_addr_q]  <= ld_mean_q;
      scale_mem[ld_addr_q] <= rsq_res.scale;
      bias_mem[ld_addr_q]  <= ld_bias_q;
    end
    if (pop_sample) begin
      rd_mean_q  <= mean_mem[head_addr];
      rd_scale_q <= scale_mem[head_addr];
      rd_bias_q  <= bias_mem[head_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_load) begin
      ld_addr_q <= head_addr;
      ld_inr_q  <= head_inr;
      ld_mean_q <= head_i.mean;
      ld_bias_q <= head_i.bias;
    end
  end

  assign s1_mean  = s1_inr_q ? rd_mean_q  : '0;
  assign s1_scale = s1_inr_q ? rd_scale_q : '0;
  assign s1_bias  = s1_inr_q ? rd_bias_q  : '0;
  assign diff     = (DATA_WIDTH+1)'(s1_x_q) - (DATA_WIDTH+1)'(s1_mean);

  assign y_wide = 34'(s2_prod_q >>> 16) + 34'(s2_bias_q);
  always_comb begin
    y_ovf = (y_wide[33:DATA_WIDTH-1] != '0) && (y_wide[33:DATA_WIDTH-1] != '1);
    if (!y_ovf) begin
      y_sat = y_wide[DATA_WIDTH-1:0];
    end else if (y_wide[33]) begin
      y_sat = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_sample) begin
      s1_ch_q   <= head_i.ch;
      s1_last_q <= head_i.last;
      s1_x_q    <= head_i.sample;
      s1_inr_q  <= head_inr;
    end
    if (en) begin
      s2_ch_q    <= s1_ch_q;
      s2_last_q  <= s1_last_q;
      s2_bias_q  <= s1_bias;
      s2_prod_q  <= 49'(diff) * 49'(s1_scale);
      out_ch_q   <= s2_ch_q;
      out_last_q <= s2_last_q;
      out_y_q    <= y_sat;
      out_sat_q  <= y_ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= pop_sample;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign normalized_value_o = out_y_q;
  assign result_channel_o   = out_ch_q;
  assign saturated_o        = out_sat_q;
  assign last_out_o         = out_last_q;

  `BNI_ASSERT_NXT(a_bk_loadbusy, pop_load, busy, "load popped but unit not busy")
  `BNI_ASSERT_IMP(a_bk_nowrpop, rsq_res.done, !pop_o, "pop during table write")

endmodule

`default_nettype wire

### design/batch_norm_inference.sv
// samples: one per cycle unless held by a busy load unit or an output stall; path front,
//   queue, read, multiply, out; loads: 59 divider steps, 26 square root steps, multiply,
//   saturate in the load unit; samples behind a load wait in the queue until its table write
// reset: asynchronous, active low; clears the counter, num_channels (to 64) and all
//   valid flags; the channel tables keep no reset and have no clearing pass
`default_nettype none

module batch_norm_inference import bni_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // num_channels register
  input  wire logic                          cfg_we_i,
  input  wire logic [CFG_WIDTH-1:0]          cfg_wdata_i,
  // request channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          operation_i,
  input  wire logic [CH_WIDTH-1:0]           channel_index_i,
  input  wire logic signed [DATA_WIDTH-1:0]  sample_value_i,
  input  wire logic                          last_in_image_i,
  input  wire logic signed [DATA_WIDTH-1:0]  channel_mean_i,
  input  wire logic [DATA_WIDTH-1:0]         channel_variance_i,
  input  wire logic signed [DATA_WIDTH-1:0]  channel_gamma_i,
  input  wire logic signed [DATA_WIDTH-1:0]  channel_bias_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [DATA_WIDTH-1:0]       normalized_value_o,
  output logic [CH_WIDTH-1:0]                result_channel_o,
  output logic                               saturated_o,
  output logic                               last_out_o
);

  // front to queue
  logic  push, full;
  item_t push_item;
  // queue to back
  logic  head_valid, pop;
  item_t head;

  // front end tags samples with their channel and forwards loads unchanged
  bni_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .operation_i        (operation_i),
    .channel_index_i    (channel_index_i),
    .sample_value_i     (sample_value_i),
    .last_in_image_i    (last_in_image_i),
    .channel_mean_i     (channel_mean_i),
    .channel_variance_i (channel_variance_i),
    .channel_gamma_i    (channel_gamma_i),
    .channel_bias_i     (channel_bias_i),
    .full_i             (full),
    .push_o             (push),
    .item_o             (push_item)
  );

  // the request is stalled only when the queue is full
  assign in_stall_o = full;

  // decouples input acceptance from load unit and output stalls
  bni_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .valid_o (head_valid),
    .head_o  (head),
    .pop_i   (pop)
  );

  // back end runs loads through the rsqrt unit and samples through the pipeline
  bni_back #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_valid_i       (head_valid),
    .head_i             (head),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .normalized_value_o (normalized_value_o),
    .result_channel_o   (result_channel_o),
    .saturated_o        (saturated_o),
    .last_out_o         (last_out_o)
  );

endmodule

`default_nettype wire

### dv/batch_norm_inference_tb.sv
// testbench for batch_norm_inference: loads channel parameters, streams samples
// and checks every result against an in-bench integer predictor; depends on bni_pkg
`timescale 1ns / 100ps

module batch_norm_inference_tb;
  import bni_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  // a full queue of loads plus the one in the load unit
  localparam int LOAD_DRAIN     = 600;

  typedef struct {
    logic signed [DATA_WIDTH-1:0] value;
    logic [CH_WIDTH-1:0]          ch;
    logic                         sat;
    logic                         last;
  } norm_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_WIDTH-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic operation_i = 1'b0;
  logic [CH_WIDTH-1:0] channel_index_i = '0;
  logic signed [DATA_WIDTH-1:0] sample_value_i = '0;
  logic last_in_image_i = 1'b0;
  logic signed [DATA_WIDTH-1:0] channel_mean_i = '0;
  logic [DATA_WIDTH-1:0] channel_variance_i = '0;
  logic signed [DATA_WIDTH-1:0] channel_gamma_i = '0;
  logic signed [DATA_WIDTH-1:0] channel_bias_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [DATA_WIDTH-1:0] normalized_value_o;
  logic [CH_WIDTH-1:0] result_channel_o;
  logic saturated_o;
  logic last_out_o;

  always #5 clk_i = ~clk_i;

  batch_norm_inference dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .operation_i, .channel_index_i, .sample_value_i,
    .last_in_image_i, .channel_mean_i, .channel_variance_i, .channel_gamma_i,
    .channel_bias_i, .out_valid_o, .out_stall_i, .normalized_value_o,
    .result_channel_o, .saturated_o, .last_out_o
  );

  // predictor state
  longint mean_tbl [MAX_CHANNELS_DEF];
  longint scale_tbl [MAX_CHANNELS_DEF];
  longint bias_tbl [MAX_CHANNELS_DEF];
  bit loaded [MAX_CHANNELS_DEF];
  int unsigned chan_count;
  int unsigned num_ch;

  norm_result_t expected_q[$];
  int mismatches;
  bit timed_out;
  int idle_cycles;
  bit stall_hold;      // forces a long output stall
  bit long_gaps;       // allows long input gaps and random output stalls

  // floor division by 2^s
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // round(2^16 / sqrt(var/256 + 1e-5)), ties up
  function automatic longint unsigned recip_std(longint unsigned variance);
    longint unsigned num, den, q, rem, r, base;
    num = 64'd25600000 << 32;
    den = 64'd100000 * variance + 64'd256;
    q = num / den;
    rem = num - q * den;
    r = int_sqrt(q);
    base = r * r + r;
    if (q >= base + 1) return r + 1;
    if (q == base && 4 * rem >= den) return r + 1;
    return r;
  endfunction

  function automatic void store_channel(int idx, logic signed [15:0] mean,
                                        logic [15:0] variance, logic signed [15:0] gamma,
                                        logic signed [15:0] bias);
    longint sc;
    sc = floor_shr(longint'(gamma) * longint'(recip_std(variance)), 8);
    if (sc > 64'sd2147483647) sc = 64'sd2147483647;
    if (sc < -64'sd2147483648) sc = -64'sd2147483648;
    mean_tbl[idx] = mean;
    scale_tbl[idx] = sc;
    bias_tbl[idx] = bias;
    loaded[idx] = 1'b1;
  endfunction

  function automatic norm_result_t normalize(logic signed [15:0] x, logic last);
    norm_result_t r;
    longint diff, sh, sl, y;
    int unsigned nxt;
    diff = longint'(x) - mean_tbl[chan_count];
    sh = floor_shr(scale_tbl[chan_count], 16);
    sl = scale_tbl[chan_count] - sh * 65536;
    y = diff * sh + floor_shr(diff * sl, 16) + bias_tbl[chan_count];
    r.sat = 1'b0;
    if (y > 32767) begin y = 32767; r.sat = 1'b1; end
    if (y < -32768) begin y = -32768; r.sat = 1'b1; end
    r.value = y[15:0];
    r.ch = chan_count[9:0];
    r.last = last;
    nxt = (chan_count + 1) & 10'h3ff;
    if (last || chan_count + 1 >= num_ch) nxt = 0;
    chan_count = nxt;
    return r;
  endfunction

  function automatic int short_or_long_gap();
    if (long_gaps && $urandom_range(0, 19) == 0) return $urandom_range(5, 30);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // send one request, waiting for acceptance; valid stays up for the next request
  task automatic send_request(op_e op, logic [9:0] ch, logic signed [15:0] x, logic last,
                              logic signed [15:0] mean, logic [15:0] variance,
                              logic signed [15:0] gamma, logic signed [15:0] bias);
    int gap;
    gap = long_gaps ? short_or_long_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    channel_index_i <= ch;
    sample_value_i <= x;
    last_in_image_i <= last;
    channel_mean_i <= mean;
    channel_variance_i <= variance;
    channel_gamma_i <= gamma;
    channel_bias_i <= bias;
    do @(posedge clk_i); while (in_stall_o);
    // predict at acceptance
    if (op == OP_LOAD) store_channel(ch, mean, variance, gamma, bias);
    else expected_q.push_back(normalize(x, last));
  endtask

  task automatic load_channel(int ch, logic signed [15:0] mean, logic [15:0] variance,
                              logic signed [15:0] gamma, logic signed [15:0] bias);
    send_request(OP_LOAD, ch[9:0], 16'($urandom), 1'($urandom), mean, variance, gamma, bias);
  endtask

  task automatic send_sample(logic signed [15:0] x, logic last);
    send_request(OP_SAMPLE, 10'($urandom), x, last, 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom));
  endtask

  // drop valid, drain everything, then allow the load unit to finish
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (LOAD_DRAIN) @(posedge clk_i);
  endtask

  task automatic write_channels(int n);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= n[CFG_WIDTH-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    num_ch = n;
  endtask

  // make sure channels [0, n) all hold parameters
  task automatic load_all(int n);
    for (int c = 0; c < n; c++)
      if (!loaded[c])
        load_channel(c, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // extremes of the data fields and the scale saturation corners
  task automatic test_directed();
    write_channels(4);
    load_channel(0, 16'sh7fff, 16'h0000, 16'sh7fff, 16'sh7fff);  // zero variance, scale clips
    load_channel(1, -16'sh8000, 16'hffff, -16'sh8000, -16'sh8000);
    load_channel(2, 16'sh0000, 16'h0100, 16'sh0100, 16'sh0000);   // unity
    load_channel(3, 16'sh0000, 16'h0000, -16'sh8000, 16'sh0000);  // negative clip
    send_sample(-16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh1234, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(-16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(-16'sh0001, 1'b1);                               // counter restarts
    send_sample(16'sh0000, 1'b0);
    load_channel(1023, 16'sh0001, 16'h0001, 16'sh0001, 16'sh0001);
    send_sample(16'sh0100, 1'b0);
  endtask

  // well-formed images with random content and loads mixed in
  task automatic test_random_stream(int n_items, int nch);
    int top;
    write_channels(nch);
    // only the channels the counter can reach in this run
    top = int'(chan_count) + n_items;
    if (top > nch) top = nch;
    if (top <= int'(chan_count)) top = int'(chan_count) + 1;
    if (top > MAX_CHANNELS_DEF) top = MAX_CHANNELS_DEF;
    load_all(top);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 9) == 0)
        load_channel($urandom_range(0, nch - 1), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom));
      else
        send_sample(16'($urandom), $urandom_range(0, 15) == 0);
    end
  endtask

  // one long output stall while requests keep coming
  task automatic test_backpressure();
    write_channels(8);
    load_all(8);
    stall_hold = 1'b1;
    fork
      begin
        repeat (60) @(posedge clk_i);
        stall_hold = 1'b0;
      end
      for (int i = 0; i < 30; i++) send_sample(16'($urandom), 1'b0);
    join
  endtask

  // random output stalls
  always @(posedge clk_i) begin
    if (stall_hold) out_stall_i <= 1'b1;
    else if (!long_gaps) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 3) == 0);
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d ch %0d",
                                       normalized_value_o, result_channel_o);
      end else begin
        norm_result_t e;
        e = expected_q.pop_front();
        if (e.value !== normalized_value_o || e.ch !== result_channel_o ||
            e.sat !== saturated_o || e.last !== last_out_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                     e.value, e.ch, e.sat, e.last, normalized_value_o,
                     result_channel_o, saturated_o, last_out_o);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    timed_out = 1'b0;
    idle_cycles = 0;
    stall_hold = 1'b0;
    long_gaps = 1'b0;
    chan_count = 0;
    num_ch = 64;
    for (int i = 0; i < MAX_CHANNELS_DEF; i++) loaded[i] = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    long_gaps = 1'b1;
    test_random_stream(40, 1);
    test_random_stream(100, 3);
    test_backpressure();
    test_random_stream(80, 64);
    test_random_stream(30, 1024);
    test_random_stream(30, 2047);   // num_channels above 1024
    long_gaps = 1'b0;
    test_random_stream(40, 5);      // back to back, no idling
    wait_idle();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+design
design/bni_pkg.sv
design/bni_front.sv
design/bni_queue.sv
design/bni_rsqrt.sv
design/bni_back.sv
design/batch_norm_inference.sv
dv/batch_norm_inference_tb.sv
